// ----- rtl/core/xjp_pkg.sv -----
// xjp_pkg: shared constants, types and table functions of the XSVF player.
// Holds opcode, action, error and TAP state codes and the TMS routing table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xjp_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int MAX_BITS     = BUFFER_BYTES * 8;
  localparam int ADDR_W       = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int BITS_W       = $clog2(MAX_BITS + 1);
  localparam int CNT_W        = ($clog2(BUFFER_BYTES + 1) > 3) ? $clog2(BUFFER_BYTES + 1) : 3;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic OP_BYTE = 1'b0;

  localparam logic [2:0] ACT_IDLE  = 3'd0;
  localparam logic [2:0] ACT_PULSE = 3'd1;
  localparam logic [2:0] ACT_WAIT  = 3'd2;
  localparam logic [2:0] ACT_DONE  = 3'd3;
  localparam logic [2:0] ACT_ERR   = 3'd4;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNSUP    = 3'd1;
  localparam logic [2:0] E_MISMATCH = 3'd2;
  localparam logic [2:0] E_OPCODE   = 3'd3;
  localparam logic [2:0] E_LENGTH   = 3'd4;

  localparam logic [3:0] TAP_RESET    = 4'd0;
  localparam logic [3:0] TAP_IDLE     = 4'd1;
  localparam logic [3:0] TAP_SHIFT_DR = 4'd4;
  localparam logic [3:0] TAP_PAUSE_DR = 4'd6;
  localparam logic [3:0] TAP_SHIFT_IR = 4'd11;
  localparam logic [3:0] TAP_PAUSE_IR = 4'd13;

  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_ARGS    = 3'd1;
  localparam logic [2:0] PH_TDI     = 3'd2;
  localparam logic [2:0] PH_EXP     = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_COMMENT = 3'd5;
  localparam logic [2:0] PH_EXEC    = 3'd6;

  localparam logic [1:0] MU_NAV   = 2'd0;
  localparam logic [1:0] MU_SHIFT = 2'd1;
  localparam logic [1:0] MU_WAIT  = 2'd2;

  localparam logic [1:0] CMP_NONE = 2'd0;
  localparam logic [1:0] CMP_MASK = 2'd1;
  localparam logic [1:0] CMP_FULL = 2'd2;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic [7:0] XCOMPLETE    = 8'h00;
  localparam logic [7:0] XTDOMASK     = 8'h01;
  localparam logic [7:0] XSIR         = 8'h02;
  localparam logic [7:0] XSDR         = 8'h03;
  localparam logic [7:0] XRUNTEST     = 8'h04;
  localparam logic [7:0] XREPEAT      = 8'h07;
  localparam logic [7:0] XSDRSIZE     = 8'h08;
  localparam logic [7:0] XSDRTDO      = 8'h09;
  localparam logic [7:0] XSETSDRMASKS = 8'h0a;
  localparam logic [7:0] XSDRINC      = 8'h0b;
  localparam logic [7:0] XSDRB        = 8'h0c;
  localparam logic [7:0] XSDRC        = 8'h0d;
  localparam logic [7:0] XSDRE        = 8'h0e;
  localparam logic [7:0] XSDRTDOB     = 8'h0f;
  localparam logic [7:0] XSDRTDOC     = 8'h10;
  localparam logic [7:0] XSDRTDOE     = 8'h11;
  localparam logic [7:0] XSTATE       = 8'h12;
  localparam logic [7:0] XENDIR       = 8'h13;
  localparam logic [7:0] XENDDR       = 8'h14;
  localparam logic [7:0] XSIR2        = 8'h15;
  localparam logic [7:0] XCOMMENT     = 8'h16;
  localparam logic [7:0] XWAIT        = 8'h17;

  typedef struct packed {
    logic       operation;
    logic [7:0] stream_byte;
    logic       tdo_bit;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic stopped;
  } stat_t;

  // next TAP state, {tms=1, tms=0}
  function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
    logic [7:0] nx;
    case (s)
      4'd0:    nx = {4'd0, 4'd1};
      4'd1:    nx = {4'd2, 4'd1};
      4'd2:    nx = {4'd9, 4'd3};
      4'd3:    nx = {4'd5, 4'd4};
      4'd4:    nx = {4'd5, 4'd4};
      4'd5:    nx = {4'd8, 4'd6};
      4'd6:    nx = {4'd7, 4'd6};
      4'd7:    nx = {4'd8, 4'd4};
      4'd8:    nx = {4'd2, 4'd1};
      4'd9:    nx = {4'd0, 4'd10};
      4'd10:   nx = {4'd12, 4'd11};
      4'd11:   nx = {4'd12, 4'd11};
      4'd12:   nx = {4'd15, 4'd13};
      4'd13:   nx = {4'd14, 4'd13};
      4'd14:   nx = {4'd15, 4'd11};
      default: nx = {4'd2, 4'd1};
    endcase
    return tms ? nx[7:4] : nx[3:0];
  endfunction

  // TMS for the first step of a shortest path, indexed {from, to}
  function automatic logic [255:0] build_tms_tab();
    logic [255:0] t;
    logic [5:0]   d [16];
    logic [5:0]   a, b, m;
    t = '0;
    for (int to = 0; to < 16; to++) begin
      for (int i = 0; i < 16; i++) d[i] = 6'd32;
      d[to] = 6'd0;
      for (int r = 0; r < 16; r++) begin
        for (int i = 0; i < 16; i++) begin
          a = d[tap_next(4'(i), 1'b0)];
          b = d[tap_next(4'(i), 1'b1)];
          m = ((a < b) ? a : b) + 6'd1;
          if (m < d[i]) d[i] = m;
        end
      end
      for (int f = 0; f < 16; f++) begin
        t[{4'(f), 4'(to)}] = (d[tap_next(4'(f), 1'b1)] < d[tap_next(4'(f), 1'b0)]);
      end
    end
    return t;
  endfunction

  localparam logic [255:0] TMS_TAB = build_tms_tab();

  function automatic logic [CNT_W-1:0] bytes_of(input logic [BITS_W-1:0] bits);
    return CNT_W'(bits >> 3) + CNT_W'(|bits[2:0]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xjp_if.sv -----
// xjp_if: request and result channels of the XSVF player, valid/ready with payload.
// Standalone; widths follow the player's item and result fields.
`timescale 1ns / 1ps
`default_nettype none

interface xjp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] stream_byte;
  logic       tdo_bit;
  modport source (output valid, operation, stream_byte, tdo_bit, input ready);
  modport sink   (input valid, operation, stream_byte, tdo_bit, output ready);
endinterface

interface xjp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        tms_level;
  logic        tdi_level;
  logic [31:0] wait_amount;
  logic [2:0]  error_code;
  logic [3:0]  tap_now;
  logic        byte_ready;
  modport source (output valid, action, tms_level, tdi_level, wait_amount, error_code,
                  tap_now, byte_ready, input ready);
  modport sink   (input valid, action, tms_level, tdi_level, wait_amount, error_code,
                  tap_now, byte_ready, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xsvf_jtag_player_unit.sv -----
// Channel   Dir  Payload                                              Handshake
// in_chan   in   operation, stream_byte, tdo_bit                      valid/ready
// out_chan  out  action, tms_level, tdi_level, wait_amount,           valid/ready
//                error_code, tap_now, byte_ready
// One request per clock while the queue is not full and the stores are not being cleared;
// each taken request is queued, and its result is registered for out_chan. Every request,
// byte or advance, is finished in one pass of the back end. Reset: in_chan.ready stays low
// while the expected and mask stores are cleared, one entry per cycle, BUFFER_BYTES (512) entries.
// A two-entry queue keeps taking requests while a result waits on out_chan.
// Depends on xjp_pkg, xjp_if, xjp_front and xjp_back.
`timescale 1ns / 1ps
`default_nettype none

module xsvf_jtag_player_unit import xjp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  xjp_in_if.sink     in_chan,
  xjp_out_if.source  out_chan
);

  logic  head_valid;
  item_t head;
  logic  pop;
  stat_t stat;

  xjp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold       (stat.clearing),
    .in_chan    (in_chan),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  xjp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .stat       (stat),
    .out_chan   (out_chan)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_chan.ready)
    else $error("request taken during store clear");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stat.stopped) |-> stat.stopped)
    else $error("player left stopped state");

  a_stop_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.stopped && out_chan.valid) |->
      ((out_chan.action == ACT_DONE || out_chan.action == ACT_ERR) && !out_chan.byte_ready))
    else $error("non-terminal result after stop");

endmodule

`default_nettype wire

// ----- rtl/core/xjp_front.sv -----
// xjp_front: input side of the player; takes requests into a short queue.
// Depends on xjp_pkg and xjp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module xjp_front import xjp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  hold,
  xjp_in_if.sink     in_chan,
  output logic       head_valid,
  output item_t      head,
  input  wire logic  pop
);

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;

  assign in_chan.ready = (cnt_r != (QPTR_W+1)'(QDEPTH)) && !hold;
  assign push          = in_chan.valid && in_chan.ready;
  assign head_valid    = (cnt_r != '0);
  assign head          = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{operation: in_chan.operation, stream_byte: in_chan.stream_byte,
                     tdo_bit: in_chan.tdo_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/xjp_back.sv -----
// xjp_back: command parser, plan sequencer, bit stores and result register.
// Depends on xjp_pkg and xjp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module xjp_back import xjp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire item_t head,
  output logic       pop,
  output stat_t      stat,
  xjp_out_if.source  out_chan
);

  // stores
  logic [7:0] tdi_mem [BUFFER_BYTES];
  logic [7:0] exp_mem [BUFFER_BYTES];
  logic [7:0] msk_mem [BUFFER_BYTES];
  logic [7:0] tdi_rd_r, exp_rd_r, msk_rd_r;

  // state
  logic [3:0]        tap_r, tap_nxt;
  logic [4:0]        opc_r, opc_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  pcnt_r, pcnt_nxt;
  logic [BITS_W-1:0] dlen_r, dlen_nxt;
  logic [31:0]       rt_r, rt_nxt;
  logic              irp_r, irp_nxt, drp_r, drp_nxt;
  logic [BITS_W-1:0] bitp_r, bitp_nxt;
  logic [1:0]        stopf_r, stopf_nxt;
  logic [2:0]        scode_r, scode_nxt;
  logic [47:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]  sidx_r, sidx_nxt;
  logic [BITS_W-1:0] sbits_r, sbits_nxt;
  logic              pendv_r, pendv_nxt, pendb_r, pendb_nxt;
  logic [2:0]        stepc_r, stepc_nxt;
  logic [1:0]        pk_r [4];
  logic [1:0]        pk_nxt [4];
  logic [3:0]        pt_r [4];
  logic [3:0]        pt_nxt [4];
  logic [1:0]        pc_r [4];
  logic [1:0]        pc_nxt [4];
  logic              pe_r [4];
  logic              pe_nxt [4];
  logic [2:0]        plen_r, plen_nxt;
  logic [2:0]        ppos_r, ppos_nxt;
  logic [31:0]       pwait_r, pwait_nxt;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_idx_r;

  // result register
  logic        ov_r;
  logic [2:0]  o_act_r, o_act;
  logic        o_tms_r, o_tms, o_tdi_r, o_tdi;
  logic [31:0] o_wait_r, o_wait;
  logic [2:0]  o_err_r, o_err;
  logic [3:0]  o_tap_r;
  logic        o_br_r;

  // step scratch
  logic              step;
  logic [7:0]        b_c;
  logic              bp_req, pf_req, build_req, start_req, settle_req, done_c;
  logic [2:0]        bp_which, pf_which;
  logic [BITS_W-1:0] bp_bits;
  logic [CNT_W-1:0]  nb_c;
  logic [7:0]        op8;
  logic [1:0]        mk;
  logic [3:0]        mt;
  logic [2:0]        bsel;
  logic              st_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr, cw_addr;
  logic [7:0]        cw_data;
  logic              cw_we;

  assign step = head_valid && !clr_r && (!ov_r || out_chan.ready);
  assign pop  = step;
  assign stat = '{clearing: clr_r, stopped: (stopf_r != ST_RUN)};
  assign b_c  = head.stream_byte;
  assign bsel = bitp_r[2:0];

  always_comb begin
    tap_nxt = tap_r;  opc_nxt = opc_r;  phase_nxt = phase_r;  pcnt_nxt = pcnt_r;
    dlen_nxt = dlen_r;  rt_nxt = rt_r;  irp_nxt = irp_r;  drp_nxt = drp_r;
    bitp_nxt = bitp_r;  stopf_nxt = stopf_r;  scode_nxt = scode_r;  acc_nxt = acc_r;
    sidx_nxt = sidx_r;  sbits_nxt = sbits_r;  pendv_nxt = pendv_r;  pendb_nxt = pendb_r;
    stepc_nxt = stepc_r;  pk_nxt = pk_r;  pt_nxt = pt_r;  pc_nxt = pc_r;  pe_nxt = pe_r;
    plen_nxt = plen_r;  ppos_nxt = ppos_r;  pwait_nxt = pwait_r;
    o_act = ACT_IDLE;  o_tms = 1'b0;  o_tdi = 1'b0;  o_wait = '0;  o_err = E_NONE;
    bp_req = 1'b0;  bp_which = PH_TDI;  bp_bits = '0;  pf_req = 1'b0;  pf_which = PH_TDI;
    build_req = 1'b0;  start_req = 1'b0;  settle_req = 1'b0;  done_c = 1'b0;
    nb_c = '0;  st_we = 1'b0;  op8 = '0;
    mk = pk_r[ppos_r[1:0]];
    mt = pt_r[ppos_r[1:0]];

    if (step && stopf_r == ST_RUN) begin
      if (head.operation == OP_BYTE) begin
        case (phase_r)
          PH_OPCODE: begin
            opc_nxt = b_c[4:0];
            unique case (b_c) inside
              XCOMPLETE: begin
                stopf_nxt = ST_DONE;  scode_nxt = E_NONE;
              end
              XSETSDRMASKS, XSDRINC: begin
                stopf_nxt = ST_FAIL;  scode_nxt = E_UNSUP;
              end
              XTDOMASK: begin
                bp_req = 1'b1;  bp_which = PH_MASK;  bp_bits = dlen_r;
              end
              XSDR, XSDRTDO, XSDRB, XSDRC, XSDRE, XSDRTDOB, XSDRTDOC, XSDRTDOE: begin
                bp_req = 1'b1;  bp_which = PH_TDI;  bp_bits = dlen_r;
              end
              XSIR, XREPEAT, XSTATE, XENDIR, XENDDR: begin
                phase_nxt = PH_ARGS;  pcnt_nxt = CNT_W'(1);  acc_nxt = '0;
              end
              XSIR2: begin
                phase_nxt = PH_ARGS;  pcnt_nxt = CNT_W'(2);  acc_nxt = '0;
              end
              XRUNTEST, XSDRSIZE: begin
                phase_nxt = PH_ARGS;  pcnt_nxt = CNT_W'(4);  acc_nxt = '0;
              end
              XWAIT: begin
                phase_nxt = PH_ARGS;  pcnt_nxt = CNT_W'(6);  acc_nxt = '0;
              end
              XCOMMENT: phase_nxt = PH_COMMENT;
              default: begin
                stopf_nxt = ST_FAIL;  scode_nxt = E_OPCODE;
              end
            endcase
          end
          PH_ARGS: begin
            acc_nxt = {acc_r[39:0], b_c};
            if (pcnt_r != '0) pcnt_nxt = pcnt_r - 1'b1;
            if (pcnt_nxt == '0) begin
              phase_nxt = PH_OPCODE;
              case ({3'b000, opc_r})
                XRUNTEST: rt_nxt = acc_nxt[31:0];
                XSDRSIZE: begin
                  if (acc_nxt > 48'(MAX_BITS)) begin
                    stopf_nxt = ST_FAIL;  scode_nxt = E_LENGTH;
                  end else begin
                    dlen_nxt = acc_nxt[BITS_W-1:0];
                  end
                end
                XSTATE: begin
                  plen_nxt = 3'd1;
                  pk_nxt[0] = MU_NAV;  pt_nxt[0] = acc_nxt[3:0];
                  start_req = 1'b1;
                end
                XENDIR: irp_nxt = (acc_nxt != '0);
                XENDDR: drp_nxt = (acc_nxt != '0);
                XSIR, XSIR2: begin
                  if (acc_nxt > 48'(MAX_BITS)) begin
                    stopf_nxt = ST_FAIL;  scode_nxt = E_LENGTH;
                  end else begin
                    sbits_nxt = acc_nxt[BITS_W-1:0];
                    bp_req = 1'b1;  bp_which = PH_TDI;  bp_bits = acc_nxt[BITS_W-1:0];
                  end
                end
                XWAIT: begin
                  plen_nxt = 3'd3;
                  pk_nxt[0] = MU_NAV;   pt_nxt[0] = acc_nxt[43:40];
                  pk_nxt[1] = MU_WAIT;  pwait_nxt = acc_nxt[31:0];
                  pk_nxt[2] = MU_NAV;   pt_nxt[2] = acc_nxt[35:32];
                  start_req = 1'b1;
                end
                default: ;
              endcase
            end
          end
          PH_COMMENT: begin
            if (b_c == 8'd0) phase_nxt = PH_OPCODE;
          end
          PH_TDI, PH_EXP, PH_MASK: begin
            st_we = (sidx_r < CNT_W'(BUFFER_BYTES));
            sidx_nxt = sidx_r + 1'b1;
            if (pcnt_r != '0) pcnt_nxt = pcnt_r - 1'b1;
            if (pcnt_nxt == '0) begin
              pf_req = 1'b1;  pf_which = phase_r;
            end
          end
          default: ;
        endcase

        if (bp_req) begin
          nb_c = bytes_of(bp_bits);
          if (nb_c != '0) begin
            phase_nxt = bp_which;  pcnt_nxt = nb_c;  sidx_nxt = '0;
          end else begin
            pf_req = 1'b1;  pf_which = bp_which;
          end
        end

        op8 = {3'b000, opc_nxt};
        if (pf_req) begin
          nb_c = bytes_of(dlen_r);
          if (pf_which == PH_MASK) begin
            phase_nxt = PH_OPCODE;
          end else if (pf_which == PH_TDI && nb_c != '0 &&
                       (op8 == XSDRTDO || op8 == XSDRTDOB || op8 == XSDRTDOC ||
                        op8 == XSDRTDOE)) begin
            phase_nxt = PH_EXP;  pcnt_nxt = nb_c;  sidx_nxt = '0;
          end else begin
            build_req = 1'b1;
          end
        end

        if (build_req) begin
          for (int i = 0; i < 4; i++) begin
            pc_nxt[i] = CMP_NONE;  pe_nxt[i] = 1'b0;
          end
          if (op8 == XSIR || op8 == XSIR2) begin
            pk_nxt[0] = MU_NAV;    pt_nxt[0] = TAP_SHIFT_IR;
            pk_nxt[1] = MU_SHIFT;  pe_nxt[1] = 1'b1;
            if (rt_r != '0) begin
              pk_nxt[2] = MU_NAV;  pt_nxt[2] = TAP_IDLE;
              pk_nxt[3] = MU_WAIT; pwait_nxt = rt_r;  plen_nxt = 3'd4;
            end else begin
              pk_nxt[2] = MU_NAV;  pt_nxt[2] = irp_r ? TAP_PAUSE_IR : TAP_IDLE;
              plen_nxt = 3'd3;
            end
          end else begin
            sbits_nxt = dlen_r;
            pk_nxt[0] = MU_NAV;    pt_nxt[0] = TAP_SHIFT_DR;
            pk_nxt[1] = MU_SHIFT;
            pk_nxt[2] = MU_NAV;    pt_nxt[2] = drp_r ? TAP_PAUSE_DR : TAP_IDLE;
            plen_nxt = 3'd3;
            if (op8 == XSDR || op8 == XSDRTDO) begin
              pc_nxt[1] = CMP_MASK;  pe_nxt[1] = 1'b1;
              if (rt_r != '0) begin
                pt_nxt[2] = TAP_IDLE;
                pk_nxt[3] = MU_WAIT;  pwait_nxt = rt_r;  plen_nxt = 3'd4;
              end
            end else if (op8 == XSDRB || op8 == XSDRC) begin
              plen_nxt = 3'd2;
            end else if (op8 == XSDRE) begin
              pe_nxt[1] = 1'b1;
            end else if (op8 == XSDRTDOB || op8 == XSDRTDOC) begin
              pc_nxt[1] = CMP_FULL;  plen_nxt = 3'd2;
            end else begin
              pc_nxt[1] = CMP_FULL;  pe_nxt[1] = 1'b1;
            end
          end
          start_req = 1'b1;
        end

        if (start_req) begin
          ppos_nxt = '0;  bitp_nxt = '0;  stepc_nxt = '0;
          phase_nxt = PH_EXEC;  settle_req = 1'b1;
        end
      end else if (phase_r == PH_EXEC) begin
        if (pendv_r) begin
          pendv_nxt = 1'b0;
          if (head.tdo_bit != pendb_r) begin
            stopf_nxt = ST_FAIL;  scode_nxt = E_MISMATCH;
          end
        end
        if (stopf_nxt == ST_RUN) begin
          if (ppos_r >= plen_r) begin
            phase_nxt = PH_OPCODE;
          end else begin
            o_act = ACT_PULSE;
            case (mk)
              MU_NAV: begin
                o_tms = (mt == TAP_RESET) ? 1'b1 : TMS_TAB[{tap_r, mt}];
                if (mt == TAP_RESET) stepc_nxt = stepc_r + 1'b1;
                tap_nxt = tap_next(tap_r, o_tms);
              end
              MU_SHIFT: begin
                o_tdi = tdi_rd_r[bsel];
                if (pc_r[ppos_r[1:0]] == CMP_FULL ||
                    (pc_r[ppos_r[1:0]] == CMP_MASK && msk_rd_r[bsel])) begin
                  pendv_nxt = 1'b1;  pendb_nxt = exp_rd_r[bsel];
                end
                o_tms = pe_r[ppos_r[1:0]] && (BITS_W'(bitp_r + 1'b1) == sbits_r);
                tap_nxt = tap_next(tap_r, o_tms);
                bitp_nxt = bitp_r + 1'b1;
              end
              default: begin
                o_act = ACT_WAIT;  o_wait = pwait_r;
                stepc_nxt = stepc_r + 1'b1;
              end
            endcase
            settle_req = 1'b1;
          end
        end
      end
    end

    if (settle_req) begin
      for (int j = 0; j < 4; j++) begin
        if (ppos_nxt < plen_nxt) begin
          case (pk_nxt[ppos_nxt[1:0]])
            MU_NAV: done_c = (pt_nxt[ppos_nxt[1:0]] == TAP_RESET) ? (stepc_nxt >= 3'd5)
                                                                 : (tap_nxt == pt_nxt[ppos_nxt[1:0]]);
            MU_SHIFT: done_c = (bitp_nxt >= sbits_nxt);
            default:  done_c = (stepc_nxt != '0);
          endcase
          if (done_c) begin
            ppos_nxt = ppos_nxt + 1'b1;  stepc_nxt = '0;  bitp_nxt = '0;
          end
        end
      end
      if (ppos_nxt >= plen_nxt && !pendv_nxt) phase_nxt = PH_OPCODE;
    end

    if (stopf_nxt != ST_RUN) begin
      o_act = (stopf_nxt == ST_DONE) ? ACT_DONE : ACT_ERR;
      o_tms = 1'b0;  o_tdi = 1'b0;  o_wait = '0;  o_err = scode_nxt;
    end
  end

  // stores: one write port, registered read with write bypass
  assign wr_addr = sidx_r[ADDR_W-1:0];
  assign rd_addr = ADDR_W'(bytes_of(sbits_nxt) - CNT_W'(1) - CNT_W'(bitp_nxt >> 3));
  assign cw_we   = clr_r || (st_we && (phase_r != PH_TDI));
  assign cw_addr = clr_r ? clr_idx_r : wr_addr;
  assign cw_data = clr_r ? 8'd0 : b_c;

  always_ff @(posedge clk) begin
    if (st_we && phase_r == PH_TDI) tdi_mem[wr_addr] <= b_c;
    tdi_rd_r <= (st_we && phase_r == PH_TDI && wr_addr == rd_addr) ? b_c : tdi_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_we && (clr_r || phase_r == PH_EXP)) exp_mem[cw_addr] <= cw_data;
    exp_rd_r <= (cw_we && (clr_r || phase_r == PH_EXP) && cw_addr == rd_addr)
                ? cw_data : exp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cw_we && (clr_r || phase_r == PH_MASK)) msk_mem[cw_addr] <= cw_data;
    msk_rd_r <= (cw_we && (clr_r || phase_r == PH_MASK) && cw_addr == rd_addr)
                ? cw_data : msk_mem[rd_addr];
  end

  // plan storage and result payload
  always_ff @(posedge clk) begin
    pk_r <= pk_nxt;  pt_r <= pt_nxt;  pc_r <= pc_nxt;  pe_r <= pe_nxt;
    pwait_r <= pwait_nxt;  acc_r <= acc_nxt;
    if (step) begin
      o_act_r <= o_act;  o_tms_r <= o_tms;  o_tdi_r <= o_tdi;  o_wait_r <= o_wait;
      o_err_r <= o_err;  o_tap_r <= tap_nxt;
      o_br_r  <= (stopf_nxt == ST_RUN) && (phase_nxt != PH_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= TAP_RESET;  opc_r <= '0;  phase_r <= PH_OPCODE;  pcnt_r <= '0;
      dlen_r <= '0;  rt_r <= '0;  irp_r <= 1'b0;  drp_r <= 1'b0;  bitp_r <= '0;
      stopf_r <= ST_RUN;  scode_r <= E_NONE;  sidx_r <= '0;  sbits_r <= '0;
      pendv_r <= 1'b0;  pendb_r <= 1'b0;  stepc_r <= '0;  plen_r <= '0;  ppos_r <= '0;
      clr_r <= 1'b1;  clr_idx_r <= '0;  ov_r <= 1'b0;
    end else begin
      tap_r <= tap_nxt;  opc_r <= opc_nxt;  phase_r <= phase_nxt;  pcnt_r <= pcnt_nxt;
      dlen_r <= dlen_nxt;  rt_r <= rt_nxt;  irp_r <= irp_nxt;  drp_r <= drp_nxt;
      bitp_r <= bitp_nxt;  stopf_r <= stopf_nxt;  scode_r <= scode_nxt;
      sidx_r <= sidx_nxt;  sbits_r <= sbits_nxt;  pendv_r <= pendv_nxt;
      pendb_r <= pendb_nxt;  stepc_r <= stepc_nxt;  plen_r <= plen_nxt;
      ppos_r <= ppos_nxt;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == ADDR_W'(BUFFER_BYTES - 1)) clr_r <= 1'b0;
      end
      if (step)                 ov_r <= 1'b1;
      else if (out_chan.ready)  ov_r <= 1'b0;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.action      = o_act_r;
  assign out_chan.tms_level   = o_tms_r;
  assign out_chan.tdi_level   = o_tdi_r;
  assign out_chan.wait_amount = o_wait_r;
  assign out_chan.error_code  = o_err_r;
  assign out_chan.tap_now     = o_tap_r;
  assign out_chan.byte_ready  = o_br_r;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for xsvf_jtag_player_unit, XSVF byte streams and TAP advances.
// A scoreboard class predicts each result; bursty sender, stalling receiver.
// Depends on xjp_pkg, xjp_if and the player RTL.
`timescale 1ns / 1ps

module tb;
  import xjp_pkg::*;

  localparam int ITEMS     = 400;
  localparam int IDLE_MAX  = 3000;
  localparam int DRAIN_CYC = 12;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       tdo;
  } req_t;

  typedef struct {
    logic [2:0]  action;
    logic        tms;
    logic        tdi;
    logic [31:0] wamt;
    logic [2:0]  err;
    logic [3:0]  tap;
    logic        brdy;
  } res_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  target;
    logic [1:0]  cmp;
    bit          exitf;
    logic [31:0] amount;
  } mop_t;

  class player_scoreboard;
    res_t             expq[$];
    int               errors;
    logic [3:0]       tap;
    logic [4:0]       opc;
    logic [2:0]       phase;
    int unsigned      pcount, dlen, rt_amt, sidx, sbits, steps, bitpos;
    bit               ir_park, dr_park;
    logic [7:0]       rep_lim;
    logic [7:0]       tdi_mem [BUFFER_BYTES];
    logic [7:0]       exp_mem [BUFFER_BYTES];
    logic [7:0]       msk_mem [BUFFER_BYTES];
    logic [1:0]       halted;
    logic [2:0]       halt_code;
    logic [63:0]      acc;
    bit               pend_valid, pend_bit;
    mop_t             plan [4];
    int unsigned      plen, ppos;

    function new();
      errors = 0; tap = TAP_RESET; opc = 0; phase = PH_OPCODE;
      pcount = 0; dlen = 0; rt_amt = 0; sidx = 0; sbits = 0; steps = 0; bitpos = 0;
      ir_park = 0; dr_park = 0; rep_lim = 0; halted = ST_RUN; halt_code = E_NONE;
      acc = 0; pend_valid = 0; pend_bit = 0; plen = 0; ppos = 0;
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        tdi_mem[i] = 0; exp_mem[i] = 0; msk_mem[i] = 0;
      end
      for (int i = 0; i < 4; i++) plan[i] = '{MU_NAV, 0, CMP_NONE, 0, 0};
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function int unsigned nbytes(int unsigned bits);
      return (bits >> 3) + ((bits & 7) != 0 ? 1 : 0);
    endfunction

    function logic [3:0] tap_step(logic [3:0] s, bit tms);
      logic [3:0] z, o;
      case (s)
        4'd0: begin z = 1; o = 0; end
        4'd1: begin z = 1; o = 2; end
        4'd2: begin z = 3; o = 9; end
        4'd3: begin z = 4; o = 5; end
        4'd4: begin z = 4; o = 5; end
        4'd5: begin z = 6; o = 8; end
        4'd6: begin z = 6; o = 7; end
        4'd7: begin z = 4; o = 8; end
        4'd8: begin z = 1; o = 2; end
        4'd9: begin z = 10; o = 0; end
        4'd10: begin z = 11; o = 12; end
        4'd11: begin z = 11; o = 12; end
        4'd12: begin z = 13; o = 15; end
        4'd13: begin z = 13; o = 14; end
        4'd14: begin z = 11; o = 15; end
        default: begin z = 1; o = 2; end
      endcase
      return tms ? o : z;
    endfunction

    function bit route_tms(logic [3:0] from, logic [3:0] to);
      int d [16];
      int a, b, m;
      for (int i = 0; i < 16; i++) d[i] = 32;
      d[to] = 0;
      for (int r = 0; r < 16; r++)
        for (int i = 0; i < 16; i++) begin
          a = d[tap_step(4'(i), 0)];
          b = d[tap_step(4'(i), 1)];
          m = ((a < b) ? a : b) + 1;
          if (m < d[i]) d[i] = m;
        end
      return d[tap_step(from, 1)] < d[tap_step(from, 0)];
    endfunction

    function void halt(logic [2:0] code);
      halted = (code != E_NONE) ? ST_FAIL : ST_DONE;
      halt_code = code;
    endfunction

    function void add_op(logic [1:0] k, logic [3:0] t, logic [1:0] c, bit x, int unsigned amt);
      if (plen < 4) begin
        plan[plen] = '{k, t, c, x, amt};
        plen++;
      end
    endfunction

    function void add_end(bit pause, logic [3:0] pstate);
      if (rt_amt != 0) begin
        add_op(MU_NAV, TAP_IDLE, CMP_NONE, 0, 0);
        add_op(MU_WAIT, 0, CMP_NONE, 0, rt_amt);
      end else add_op(MU_NAV, pause ? pstate : TAP_IDLE, CMP_NONE, 0, 0);
    endfunction

    function void settle();
      bit fin;
      while (ppos < plen) begin
        if (plan[ppos].kind == MU_NAV)
          fin = (plan[ppos].target == TAP_RESET) ? (steps >= 5) : (tap == plan[ppos].target);
        else if (plan[ppos].kind == MU_SHIFT) fin = (bitpos >= sbits);
        else fin = (steps >= 1);
        if (!fin) break;
        ppos++; steps = 0; bitpos = 0;
      end
      if (ppos >= plen && !pend_valid) phase = PH_OPCODE;
    endfunction

    function void start_plan();
      ppos = 0; bitpos = 0; steps = 0; phase = PH_EXEC;
      settle();
    endfunction

    function void build_shift();
      logic [7:0] op;
      op = 8'(opc);
      plen = 0;
      if (op == XSIR || op == XSIR2) begin
        add_op(MU_NAV, TAP_SHIFT_IR, CMP_NONE, 0, 0);
        add_op(MU_SHIFT, 0, CMP_NONE, 1, 0);
        add_end(ir_park, TAP_PAUSE_IR);
      end else begin
        sbits = dlen;
        add_op(MU_NAV, TAP_SHIFT_DR, CMP_NONE, 0, 0);
        if (op == XSDR || op == XSDRTDO) begin
          add_op(MU_SHIFT, 0, CMP_MASK, 1, 0);
          add_end(dr_park, TAP_PAUSE_DR);
        end else if (op == XSDRB || op == XSDRC) begin
          add_op(MU_SHIFT, 0, CMP_NONE, 0, 0);
        end else if (op == XSDRE) begin
          add_op(MU_SHIFT, 0, CMP_NONE, 1, 0);
          add_op(MU_NAV, dr_park ? TAP_PAUSE_DR : TAP_IDLE, CMP_NONE, 0, 0);
        end else if (op == XSDRTDOB || op == XSDRTDOC) begin
          add_op(MU_SHIFT, 0, CMP_FULL, 0, 0);
        end else begin
          add_op(MU_SHIFT, 0, CMP_FULL, 1, 0);
          add_op(MU_NAV, dr_park ? TAP_PAUSE_DR : TAP_IDLE, CMP_NONE, 0, 0);
        end
      end
      start_plan();
    endfunction

    function void payload_done(logic [2:0] which);
      logic [7:0] op;
      op = 8'(opc);
      if (which == PH_MASK) begin phase = PH_OPCODE; return; end
      if (which == PH_TDI && (op == XSDRTDO || (op >= XSDRTDOB && op <= XSDRTDOE))
          && nbytes(dlen) != 0) begin
        phase = PH_EXP; pcount = nbytes(dlen); sidx = 0;
        return;
      end
      build_shift();
    endfunction

    function void begin_payload(logic [2:0] which, int unsigned bits);
      if (nbytes(bits) != 0) begin
        phase = which; pcount = nbytes(bits); sidx = 0;
      end else payload_done(which);
    endfunction

    function void begin_args(int unsigned n);
      phase = PH_ARGS; pcount = n; acc = 0;
    endfunction

    function void args_done();
      logic [7:0] op;
      op = 8'(opc);
      phase = PH_OPCODE;
      case (op)
        XRUNTEST: rt_amt = acc[31:0];
        XREPEAT:  rep_lim = acc[7:0];
        XSDRSIZE: if (acc > MAX_BITS) halt(E_LENGTH); else dlen = acc[31:0];
        XSTATE: begin
          plen = 0;
          add_op(MU_NAV, acc[3:0], CMP_NONE, 0, 0);
          start_plan();
        end
        XENDIR: ir_park = (acc != 0);
        XENDDR: dr_park = (acc != 0);
        XSIR, XSIR2: begin
          if (acc > MAX_BITS) halt(E_LENGTH);
          else begin
            sbits = acc[31:0];
            begin_payload(PH_TDI, sbits);
          end
        end
        XWAIT: begin
          plen = 0;
          add_op(MU_NAV, acc[43:40], CMP_NONE, 0, 0);
          add_op(MU_WAIT, 0, CMP_NONE, 0, acc[31:0]);
          add_op(MU_NAV, acc[35:32], CMP_NONE, 0, 0);
          start_plan();
        end
        default: ;
      endcase
    endfunction

    function void take_opcode(logic [7:0] b);
      opc = b[4:0];
      if (b > XWAIT) begin halt(E_OPCODE); return; end
      case (b)
        XCOMPLETE: halt(E_NONE);
        XSETSDRMASKS, XSDRINC: halt(E_UNSUP);
        XTDOMASK: begin_payload(PH_MASK, dlen);
        XSDR, XSDRTDO, XSDRB, XSDRC, XSDRE, XSDRTDOB, XSDRTDOC, XSDRTDOE:
          begin_payload(PH_TDI, dlen);
        XSIR, XREPEAT, XSTATE, XENDIR, XENDDR: begin_args(1);
        XSIR2: begin_args(2);
        XRUNTEST, XSDRSIZE: begin_args(4);
        XWAIT: begin_args(6);
        XCOMMENT: phase = PH_COMMENT;
        default: halt(E_OPCODE);
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      logic [2:0] ph;
      ph = phase;
      if (ph == PH_OPCODE) take_opcode(b);
      else if (ph == PH_ARGS) begin
        acc = {acc[55:0], b};
        if (pcount > 0) pcount--;
        if (pcount == 0) args_done();
      end else if (ph == PH_COMMENT) begin
        if (b == 0) phase = PH_OPCODE;
      end else if (ph == PH_TDI || ph == PH_EXP || ph == PH_MASK) begin
        if (sidx < BUFFER_BYTES) begin
          if (ph == PH_TDI) tdi_mem[sidx] = b;
          else if (ph == PH_EXP) exp_mem[sidx] = b;
          else msk_mem[sidx] = b;
        end
        sidx++;
        if (pcount > 0) pcount--;
        if (pcount == 0) payload_done(ph);
      end
    endfunction

    function res_t make_res(logic [2:0] a, bit ms, bit di, logic [31:0] w, logic [2:0] e);
      res_t r;
      r = '{a, ms, di, w, e, tap, (halted == ST_RUN && phase != PH_EXEC)};
      return r;
    endfunction

    function res_t predict(req_t rq);
      bit ms, di;
      logic [2:0] act;
      logic [31:0] w;
      int unsigned k, bi;
      logic [7:0] bm;
      mop_t m;
      ms = 0; di = 0; act = ACT_PULSE; w = 0;
      if (halted == ST_RUN) begin
        if (rq.op == OP_BYTE) begin
          if (phase != PH_EXEC) take_byte(rq.data);
          if (halted == ST_RUN) return make_res(ACT_IDLE, 0, 0, 0, E_NONE);
        end else begin
          if (phase != PH_EXEC) return make_res(ACT_IDLE, 0, 0, 0, E_NONE);
          if (pend_valid) begin
            pend_valid = 0;
            if (rq.tdo != pend_bit) halt(E_MISMATCH);
          end
          if (halted == ST_RUN) begin
            settle();
            if (phase != PH_EXEC) return make_res(ACT_IDLE, 0, 0, 0, E_NONE);
            m = plan[ppos & 3];
            if (m.kind == MU_NAV) begin
              ms = (m.target == TAP_RESET) ? 1 : route_tms(tap, m.target);
              if (m.target == TAP_RESET) steps++;
              tap = tap_step(tap, ms);
            end else if (m.kind == MU_SHIFT) begin
              k = bitpos;
              bi = nbytes(sbits) - 1 - (k >> 3);
              bm = 8'(1 << (k & 7));
              if (bi < BUFFER_BYTES) begin
                di = (tdi_mem[bi] & bm) != 0;
                if (m.cmp == CMP_FULL || (m.cmp == CMP_MASK && (msk_mem[bi] & bm) != 0)) begin
                  pend_valid = 1;
                  pend_bit = (exp_mem[bi] & bm) != 0;
                end
              end
              ms = m.exitf && (k + 1 == sbits);
              tap = tap_step(tap, ms);
              bitpos++;
            end else begin
              act = ACT_WAIT;
              w = m.amount;
              steps++;
            end
            settle();
            return make_res(act, ms, di, w, E_NONE);
          end
        end
      end
      return make_res((halted == ST_DONE) ? ACT_DONE : ACT_ERR, 0, 0, 0, halt_code);
    endfunction

    function void note(req_t rq);
      expq.push_back(predict(rq));
    endfunction

    function void check(res_t got);
      res_t e;
      if (expq.size() == 0) begin
        $error("result with nothing expected: action %0d", got.action);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.action !== e.action) begin
        $error("action: expected %0d, got %0d", e.action, got.action); errors++;
      end
      if (got.tms !== e.tms) begin
        $error("tms_level: expected %0d, got %0d", e.tms, got.tms); errors++;
      end
      if (got.tdi !== e.tdi) begin
        $error("tdi_level: expected %0d, got %0d", e.tdi, got.tdi); errors++;
      end
      if (got.wamt !== e.wamt) begin
        $error("wait_amount: expected %0d, got %0d", e.wamt, got.wamt); errors++;
      end
      if (got.err !== e.err) begin
        $error("error_code: expected %0d, got %0d", e.err, got.err); errors++;
      end
      if (got.tap !== e.tap) begin
        $error("tap_now: expected %0d, got %0d", e.tap, got.tap); errors++;
      end
      if (got.brdy !== e.brdy) begin
        $error("byte_ready: expected %0d, got %0d", e.brdy, got.brdy); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  xjp_in_if  in_ch ();
  xjp_out_if out_ch ();

  xsvf_jtag_player_unit dut (.clk(clk), .rst_n(rst_n), .in_chan(in_ch), .out_chan(out_ch));

  player_scoreboard sb = new();

  logic [7:0]  stream_q [$];
  int unsigned gen_len = 0;
  int          accepted = 0, post_cnt = 0, gap_left = 0, burst_left = 4, idle_cnt = 0;
  int          stage = 0;
  bit          drain = 0, done = 0, term_pushed = 0, flip_tdo = 0;
  int unsigned rcv_cnt = 0;

  logic [7:0] rand_ops [18] = '{XTDOMASK, XSDR, XSDR, XSDRTDO, XSDRTDO, XSIR, XSIR2, XRUNTEST,
                                 XREPEAT, XSDRSIZE, XSDRB, XSDRC, XSDRE, XSDRTDOB, XSDRTDOC,
                                 XSDRTDOE, XSTATE, XWAIT};

  task automatic push_word(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) stream_q.push_back(v[8*i +: 8]);
  endtask

  task automatic push_rand(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) stream_q.push_back(8'($urandom));
  endtask

  task automatic push_size(input int unsigned len);
    stream_q.push_back(XSDRSIZE);
    push_word(len, 4);
    if (len <= MAX_BITS) gen_len = len;
  endtask

  task automatic push_cmd(input logic [7:0] op);
    int unsigned l, nb;
    nb = (gen_len + 7) / 8;
    case (op)
      XSDRSIZE: push_size(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40));
      XTDOMASK, XSDR, XSDRB, XSDRC, XSDRE: begin
        stream_q.push_back(op); push_rand(nb);
      end
      XSDRTDO, XSDRTDOB, XSDRTDOC, XSDRTDOE: begin
        stream_q.push_back(op); push_rand(2 * nb);
      end
      XSIR, XSIR2: begin
        l = $urandom_range(0, 24);
        stream_q.push_back(op);
        push_word(l, (op == XSIR) ? 1 : 2);
        push_rand((l + 7) / 8);
      end
      XRUNTEST: begin
        stream_q.push_back(op);
        push_word($urandom_range(0, 1) ? 0 : $urandom, 4);
      end
      XWAIT: begin stream_q.push_back(op); push_rand(6); end
      XCOMMENT: begin
        stream_q.push_back(op);
        repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom_range(1, 255)));
        stream_q.push_back(8'h00);
      end
      default: begin stream_q.push_back(op); push_rand(1); end
    endcase
  endtask

  task automatic push_terminal();
    case ($urandom_range(0, 6))
      0: stream_q.push_back(XCOMPLETE);
      1: stream_q.push_back(XSETSDRMASKS);
      2: stream_q.push_back(XSDRINC);
      3: stream_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(5, 6))
                                                 : 8'($urandom_range(8'h18, 8'hff)));
      4: push_size($urandom_range(0, 1) ? MAX_BITS + 1 : 32'hffff_ffff);
      5: begin
        stream_q.push_back(XSIR2);
        push_word($urandom_range(MAX_BITS + 1, 16'hffff), 2);
      end
      default: begin
        push_size(8);
        stream_q.push_back(XSDRTDOB);
        push_rand(2);
        flip_tdo = 1;
      end
    endcase
    term_pushed = 1;
  endtask

  task automatic push_directed();
    push_size(MAX_BITS);
    push_size(0);
    push_cmd(XSDR);
    push_cmd(XSDRTDOE);
    push_size(8);
    foreach (rand_ops[i]) if (rand_ops[i] != XSDRSIZE) push_cmd(rand_ops[i]);
    push_cmd(XENDIR);
    push_cmd(XENDDR);
    push_cmd(XCOMMENT);
    stream_q.push_back(XSTATE);
    stream_q.push_back(8'h10);
    push_size(16);
    push_cmd(XSDRTDO);
  endtask

  task automatic next_req(output req_t rq);
    rq.op = 1'b1; rq.data = 8'($urandom); rq.tdo = 1'($urandom);
    if (sb.halted != ST_RUN) begin
      rq.op = 1'($urandom);
      post_cnt++;
      if (post_cnt >= 6) done = 1;
    end else if (sb.phase == PH_EXEC) begin
      if ($urandom_range(0, 15) == 0) rq.op = OP_BYTE;
      else if (sb.pend_valid) rq.tdo = flip_tdo ? !sb.pend_bit : sb.pend_bit;
    end else if ($urandom_range(0, 19) == 0) begin
      rq.op = 1'b1;
    end else begin
      if (stream_q.size() == 0) begin
        if (stage == 0) begin stage = 1; drain = 1; end
        if (accepted < ITEMS) begin
          if ($urandom_range(0, 9) == 0) push_cmd(XCOMMENT);
          else if ($urandom_range(0, 9) == 0) push_cmd(XENDIR + 8'($urandom_range(0, 1)));
          else push_cmd(rand_ops[$urandom_range(0, 17)]);
        end else if (!term_pushed) push_terminal();
        else stream_q.push_back(XCOMPLETE);
      end
      rq.op = OP_BYTE;
      rq.data = stream_q.pop_front();
    end
  endtask

  always @(posedge clk) begin
    req_t rq, nx;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rq = '{in_ch.operation, in_ch.stream_byte, in_ch.tdo_bit};
        sb.note(rq);
        accepted++;
        if ($urandom_range(0, 199) == 0) drain = 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (drain) begin
          if (sb.pending() == 0) drain = 0;
          in_ch.valid <= 1'b0;
        end else if (done) begin
          in_ch.valid <= 1'b0;
        end else begin
          next_req(nx);
          in_ch.valid       <= 1'b1;
          in_ch.operation   <= nx.op;
          in_ch.stream_byte <= nx.data;
          in_ch.tdo_bit     <= nx.tdo;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.action, out_ch.tms_level, out_ch.tdi_level, out_ch.wait_amount,
                out_ch.error_code, out_ch.tap_now, out_ch.byte_ready};
        sb.check(got);
      end
      rcv_cnt++;
      case ((rcv_cnt >> 6) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom);
        2: out_ch.ready <= (rcv_cnt % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_MAX) begin
        $display("xsvf_jtag_player_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.stream_byte = 8'h00;
    in_ch.tdo_bit = 1'b0;
    out_ch.ready = 1'b0;
    push_directed();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!(done && !in_ch.valid && sb.pending() == 0)) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("xsvf_jtag_player_unit: match");
    else $display("xsvf_jtag_player_unit: mismatch");
    $finish;
  end

endmodule
